FILE: rtl/core/bptc_pkg.sv
`default_nettype none

package bptc_pkg;

    // Register map, one 32-bit word per coefficient.
    localparam int unsigned NUM_REGS   = 6;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_CAL_C1 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CAL_C2 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CAL_C3 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CAL_C4 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CAL_C5 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CAL_C6 = 3'd5;

    // Temperature band limits in 0.01 degC.
    localparam logic signed [21:0] TEMP_REF  = 22'sd2000;
    localparam logic signed [21:0] TEMP_COLD = -22'sd1500;

    // Widths of the intermediate quantities.
    localparam int unsigned DT_W    = 26;
    localparam int unsigned TEMP1_W = 22;
    localparam int unsigned TEMPF_W = 23;
    localparam int unsigned OFF1_W  = 40;
    localparam int unsigned T2_W    = 21;
    localparam int unsigned CORR_W  = 41;
    localparam int unsigned FINAL_W = 42;

    typedef struct packed {
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic [15:0] c4;
        logic [15:0] c5;
        logic [15:0] c6;
    } t_cal;

    // First-order quantities, before the low-temperature correction.
    typedef struct packed {
        logic                      valid;
        logic [23:0]               d1;
        logic signed [TEMP1_W-1:0] temp;
        logic signed [OFF1_W-1:0]  off;
        logic signed [OFF1_W-1:0]  sens;
        logic [T2_W-1:0]           t2;
    } t_first;

    // Fully corrected quantities, ready for the pressure calculation.
    typedef struct packed {
        logic                      valid;
        logic [23:0]               d1;
        logic signed [TEMPF_W-1:0] temp;
        logic signed [FINAL_W-1:0] off;
        logic signed [FINAL_W-1:0] sens;
    } t_second;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bptc_cfg_regs.sv
`default_nettype none

module bptc_cfg_regs import bptc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output t_cal                   o_cal
);

    t_cal                 r_cal;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    // The byte offset within a word is ignored.
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CAL_C1: r_cal.c1 <= pwdata[15:0];
                REG_CAL_C2: r_cal.c2 <= pwdata[15:0];
                REG_CAL_C3: r_cal.c3 <= pwdata[15:0];
                REG_CAL_C4: r_cal.c4 <= pwdata[15:0];
                REG_CAL_C5: r_cal.c5 <= pwdata[15:0];
                REG_CAL_C6: r_cal.c6 <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CAL_C1: prdata = {16'h0000, r_cal.c1};
            REG_CAL_C2: prdata = {16'h0000, r_cal.c2};
            REG_CAL_C3: prdata = {16'h0000, r_cal.c3};
            REG_CAL_C4: prdata = {16'h0000, r_cal.c4};
            REG_CAL_C5: prdata = {16'h0000, r_cal.c5};
            REG_CAL_C6: prdata = {16'h0000, r_cal.c6};
            default:    prdata = 32'h0000_0000;
        endcase
    end

    assign o_cal = r_cal;

endmodule

`default_nettype wire

FILE: rtl/core/bptc_first_order.sv
`default_nettype none

module bptc_first_order import bptc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [23:0] i_raw_pressure,
    input  wire logic [23:0] i_raw_temperature,
    input  wire t_cal        i_cal,
    output t_first           o_first
);

    // Stage 1: temperature difference.
    logic                   r1_valid;
    logic [23:0]            r1_d1;
    logic signed [DT_W-1:0] r1_dt;
    logic signed [DT_W-1:0] n1_dt;

    // Stage 2: the four products of dT.
    logic                   r2_valid;
    logic [23:0]            r2_d1;
    logic signed [42:0]     r2_p_temp;
    logic signed [42:0]     r2_p_off;
    logic signed [42:0]     r2_p_sens;
    logic signed [51:0]     r2_p_dd;

    // Stage 3: first-order results.
    t_first                 r3;
    t_first                 n3;

    assign n1_dt = $signed({2'b00, i_raw_temperature}) - $signed({2'b00, i_cal.c5, 8'h00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3.valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3       <= n3;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_d1     <= i_raw_pressure;
        r1_dt     <= n1_dt;
        r2_d1     <= r1_d1;
        r2_p_temp <= r1_dt * $signed({1'b0, i_cal.c6});
        r2_p_off  <= r1_dt * $signed({1'b0, i_cal.c4});
        r2_p_sens <= r1_dt * $signed({1'b0, i_cal.c3});
        r2_p_dd   <= r1_dt * r1_dt;
    end

    // Upper part-selects of the signed products are the floor of the scaled value.
    always_comb begin
        n3.valid = r2_valid;
        n3.d1    = r2_d1;
        n3.temp  = TEMP_REF + $signed(r2_p_temp[42:23]);
        n3.off   = $signed({7'b0, i_cal.c2, 17'b0}) + $signed(r2_p_off[42:6]);
        n3.sens  = $signed({8'b0, i_cal.c1, 16'b0}) + $signed(r2_p_sens[42:7]);
        // The square of dT is never negative, so its scaled value is a plain slice.
        n3.t2    = r2_p_dd[51:31];
    end

    assign o_first = r3;

endmodule

`default_nettype wire

FILE: rtl/core/bptc_second_order.sv
`default_nettype none

module bptc_second_order import bptc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_first i_first,
    output t_second   o_second
);

    // Stage 4: band flags and distances from the band limits.
    logic                      r4_valid;
    t_first                    r4_f;
    logic                      r4_warm_low;
    logic                      r4_cold;
    logic signed [22:0]        r4_a;
    logic signed [22:0]        r4_b;

    // Stage 5: squared distances and corrected temperature.
    logic                      r5_valid;
    logic [23:0]               r5_d1;
    logic signed [OFF1_W-1:0]  r5_off;
    logic signed [OFF1_W-1:0]  r5_sens;
    logic signed [TEMPF_W-1:0] r5_temp;
    logic [35:0]               r5_aa;
    logic [35:0]               r5_bb;
    logic signed [45:0]        n5_aa;
    logic signed [45:0]        n5_bb;

    // Stage 6: offset and sensitivity corrections.
    logic                      r6_valid;
    logic [23:0]               r6_d1;
    logic signed [OFF1_W-1:0]  r6_off;
    logic signed [OFF1_W-1:0]  r6_sens;
    logic signed [TEMPF_W-1:0] r6_temp;
    logic [CORR_W-1:0]         r6_off2;
    logic [CORR_W-1:0]         r6_sens2;
    logic [CORR_W+5:0]         n6_off2_x61;

    // Stage 7: corrected offset and sensitivity.
    t_second                   r7;

    assign n5_aa = r4_a * r4_a;
    assign n5_bb = r4_b * r4_b;
    // 61 * aa, as 64 * aa - 4 * aa + aa.
    assign n6_off2_x61 = ({6'b0, r5_aa, 5'b0} << 1) - {9'b0, r5_aa, 2'b0} + {11'b0, r5_aa};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7.valid <= 1'b0;
        end else begin
            r4_valid <= i_first.valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7.valid <= r6_valid;
            r7.d1    <= r6_d1;
            r7.temp  <= r6_temp;
            r7.off   <= $signed(r6_off) - $signed({1'b0, r6_off2});
            r7.sens  <= $signed(r6_sens) - $signed({1'b0, r6_sens2});
        end
    end

    always_ff @(posedge i_clk) begin
        r4_f        <= i_first;
        r4_warm_low <= i_first.temp < TEMP_REF;
        r4_cold     <= i_first.temp < TEMP_COLD;
        r4_a        <= $signed(i_first.temp) - 23'sd2000;
        r4_b        <= $signed(i_first.temp) + 23'sd1500;

        r5_d1   <= r4_f.d1;
        r5_off  <= r4_f.off;
        r5_sens <= r4_f.sens;
        // Above the reference temperature no correction applies at all.
        r5_aa   <= r4_warm_low ? n5_aa[35:0] : 36'd0;
        r5_bb   <= r4_cold ? n5_bb[35:0] : 36'd0;
        r5_temp <= r4_warm_low ? $signed(r4_f.temp) - $signed({2'b00, r4_f.t2})
                               : TEMPF_W'(r4_f.temp);

        r6_d1    <= r5_d1;
        r6_off   <= r5_off;
        r6_sens  <= r5_sens;
        r6_temp  <= r5_temp;
        r6_off2  <= n6_off2_x61[CORR_W+3:4] + CORR_W'(({5'b0, r5_bb} << 4) - {5'b0, r5_bb});
        r6_sens2 <= CORR_W'({5'b0, r5_aa} << 1) + CORR_W'({5'b0, r5_bb} << 3);
    end

    assign o_second = r7;

endmodule

`default_nettype wire

FILE: rtl/core/bptc_pressure.sv
`default_nettype none

module bptc_pressure import bptc_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_second        i_second,
    output logic                o_valid,
    output logic signed [31:0]  o_pressure,
    output logic signed [31:0]  o_temperature
);

    localparam int unsigned LO_W = FINAL_W / 2;
    localparam int unsigned HI_W = FINAL_W - LO_W;

    // Stage 8: D1 times the two halves of the sensitivity.
    logic                      r8_valid;
    logic signed [TEMPF_W-1:0] r8_temp;
    logic signed [FINAL_W-1:0] r8_off;
    logic [24+LO_W-1:0]        r8_pp_lo;
    logic signed [25+HI_W-1:0] r8_pp_hi;

    // Stage 9: full product.
    logic                      r9_valid;
    logic signed [TEMPF_W-1:0] r9_temp;
    logic signed [FINAL_W-1:0] r9_off;
    logic signed [67:0]        r9_prod;

    // Stage 10: registered outputs.
    logic                      r10_valid;
    logic signed [31:0]        r10_pressure;
    logic signed [31:0]        r10_temperature;
    logic signed [47:0]        n10_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid  <= 1'b0;
            r9_valid  <= 1'b0;
            r10_valid <= 1'b0;
        end else begin
            r8_valid  <= i_second.valid;
            r9_valid  <= r8_valid;
            r10_valid <= r9_valid;
        end
    end

    assign n10_q = $signed(r9_prod[67:21]) - r9_off;

    always_ff @(posedge i_clk) begin
        r8_temp  <= i_second.temp;
        r8_off   <= i_second.off;
        r8_pp_lo <= i_second.d1 * i_second.sens[LO_W-1:0];
        r8_pp_hi <= $signed({1'b0, i_second.d1}) * $signed(i_second.sens[FINAL_W-1:LO_W]);

        r9_temp  <= r8_temp;
        r9_off   <= r8_off;
        r9_prod  <= (68'(r8_pp_hi) <<< LO_W) + $signed({{(68-24-LO_W){1'b0}}, r8_pp_lo});

        r10_pressure    <= sat32(64'(n10_q >>> 15));
        r10_temperature <= sat32(64'(r9_temp));
    end

    assign o_valid       = r10_valid;
    assign o_pressure    = r10_pressure;
    assign o_temperature = r10_temperature;

endmodule

`default_nettype wire

FILE: rtl/core/baro_pressure_temp_compensation_unit.sv
`default_nettype none

// Compensated pressure and temperature from raw barometer conversions.
// A transaction is a pair of raw readings, D1 (pressure) and D2 (temperature),
// presented on i_raw_pressure and i_raw_temperature and taken at each clock edge
// where start is high and busy is low. busy stays low: a new pair may be given
// in every cycle, one after another without gaps.
// The six calibration coefficients are written through the APB port at word
// addresses 0x00 to 0x14 (C1 to C6, low 16 bits kept) and read back the same way.
// They are to be changed only while no transaction is in flight.
// Each transaction produces one result: o_result_valid is
// high for a single cycle with o_pressure_out (0.01 mbar) and o_temperature_out
// (0.01 degC), both saturated to signed 32 bits. Ten register stages, set by the
// dT products, the squared band distances and the split D1 x SENS product, lie
// between input and result; throughput is one transaction per cycle.
// The receiver must take every result in the cycle it appears; there is no
// back-pressure. A synchronous reset clears the coefficients to zero and drops
// any transactions in flight.

module baro_pressure_temp_compensation_unit import bptc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [23:0]       i_raw_pressure,
    input  wire logic [23:0]       i_raw_temperature,
    output logic                   o_result_valid,
    output logic signed [31:0]     o_pressure_out,
    output logic signed [31:0]     o_temperature_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_cal    cal;
    t_first  first_res;
    t_second second_res;
    logic    accept;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start & ~busy;

    bptc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cal   (cal)
    );

    bptc_first_order u_first (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (accept),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_cal             (cal),
        .o_first           (first_res)
    );

    bptc_second_order u_second (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_first  (first_res),
        .o_second (second_res)
    );

    bptc_pressure u_press (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_second      (second_res),
        .o_valid       (o_result_valid),
        .o_pressure    (o_pressure_out),
        .o_temperature (o_temperature_out)
    );

endmodule

`default_nettype wire
